FILE: hw/rtl/abst_pkg.sv
`timescale 1ns / 1ps

package abst_pkg;

    localparam int CAPACITY_DEF = 4096;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int INDEX_W      = 12;

    typedef logic [INDEX_W-1:0] t_index;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_FIND   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_status           status;
        t_index            index;
        logic [PAY_W-1:0]  payload;
    } t_result;

    // Write enables of the node memory, one per field group.
    typedef struct packed {
        logic node;
        logic left;
        logic right;
    } t_mem_we;

endpackage

FILE: hw/rtl/abst_mem.sv
`timescale 1ns / 1ps

module abst_mem #(
    parameter int DEPTH = abst_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = AW + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [abst_pkg::KEY_W-1:0] o_rd_key,
    output logic [abst_pkg::PAY_W-1:0] o_rd_pay,
    output logic [LW-1:0]             o_rd_left,
    output logic [LW-1:0]             o_rd_right,
    input  abst_pkg::t_mem_we         i_we,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [abst_pkg::KEY_W-1:0] i_wr_key,
    input  logic [abst_pkg::PAY_W-1:0] i_wr_pay,
    input  logic [LW-1:0]             i_wr_left,
    input  logic [LW-1:0]             i_wr_right
);

    logic [abst_pkg::KEY_W-1:0] r_key_mem   [DEPTH];
    logic [abst_pkg::PAY_W-1:0] r_pay_mem   [DEPTH];
    logic [LW-1:0]             r_left_mem  [DEPTH];
    logic [LW-1:0]             r_right_mem [DEPTH];

    logic [abst_pkg::KEY_W-1:0] r_rd_key;
    logic [abst_pkg::PAY_W-1:0] r_rd_pay;
    logic [LW-1:0]             r_rd_left;
    logic [LW-1:0]             r_rd_right;

    always_ff @(posedge i_clk) begin
        if (i_we.node) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_pay_mem[i_wr_addr] <= i_wr_pay;
        end
        if (i_we.left) begin
            r_left_mem[i_wr_addr] <= i_wr_left;
        end
        if (i_we.right) begin
            r_right_mem[i_wr_addr] <= i_wr_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key   <= r_key_mem[i_rd_addr];
            r_rd_pay   <= r_pay_mem[i_rd_addr];
            r_rd_left  <= r_left_mem[i_rd_addr];
            r_rd_right <= r_right_mem[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_pay   = r_rd_pay;
    assign o_rd_left  = r_rd_left;
    assign o_rd_right = r_rd_right;

endmodule

FILE: hw/rtl/abst_ctrl.sv
`timescale 1ns / 1ps

module abst_ctrl #(
    parameter int CAPACITY = abst_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int LW       = AW + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic [abst_pkg::KEY_W-1:0] i_key,
    input  logic [abst_pkg::PAY_W-1:0] i_payload,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [abst_pkg::KEY_W-1:0] i_rd_key,
    input  logic [abst_pkg::PAY_W-1:0] i_rd_pay,
    input  logic [LW-1:0]              i_rd_left,
    input  logic [LW-1:0]              i_rd_right,
    output abst_pkg::t_mem_we          o_we,
    output logic [AW-1:0]              o_wr_addr,
    output logic [abst_pkg::KEY_W-1:0] o_wr_key,
    output logic [abst_pkg::PAY_W-1:0] o_wr_pay,
    output logic [LW-1:0]              o_wr_left,
    output logic [LW-1:0]              o_wr_right,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output abst_pkg::t_result          o_res
);

    // A link of CAPACITY or more means no child; the count equals it when full.
    localparam logic [LW-1:0] NO_CHILD   = LW'(CAPACITY);
    localparam logic [LW-1:0] COUNT_FULL = LW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WRITE_PARENT,
        S_WRITE_NEW,
        S_RESULT
    } t_state;

    t_state                     r_state, n_state;
    abst_pkg::t_op              r_op, n_op;
    logic [abst_pkg::KEY_W-1:0] r_key, n_key;
    logic [abst_pkg::PAY_W-1:0] r_pay, n_pay;
    logic [AW-1:0]              r_cur, n_cur;
    logic [AW-1:0]              r_last, n_last;
    logic                       r_dir_left, n_dir_left;
    logic [LW-1:0]              r_count, n_count;
    abst_pkg::t_result          r_res, n_res;

    logic          key_less;
    logic [LW-1:0] link;

    assign key_less = r_key < i_rd_key;
    assign link     = key_less ? i_rd_left : i_rd_right;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_pay      = r_pay;
        n_cur      = r_cur;
        n_last     = r_last;
        n_dir_left = r_dir_left;
        n_count    = r_count;
        n_res      = r_res;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;
        o_we       = '0;
        o_wr_addr  = r_last;
        o_wr_key   = r_key;
        o_wr_pay   = r_pay;
        o_wr_left  = r_count;
        o_wr_right = r_count;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = abst_pkg::t_op'(i_op);
                    n_key = i_key;
                    n_pay = i_payload;
                    n_res = '0;
                    if (i_op == abst_pkg::OP_INSERT && r_count == COUNT_FULL) begin
                        n_res.status = abst_pkg::ST_FULL;
                        n_state      = S_RESULT;
                    end else if (r_count == '0) begin
                        if (i_op == abst_pkg::OP_INSERT) begin
                            n_state = S_WRITE_NEW;
                        end else begin
                            n_res.status = abst_pkg::ST_NOT_FOUND;
                            n_state      = S_RESULT;
                        end
                    end else begin
                        // Start the walk at the root.
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                        n_cur     = '0;
                        n_state   = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                // Read data belongs to node r_cur; one tree level per cycle.
                if (r_key == i_rd_key) begin
                    if (r_op == abst_pkg::OP_INSERT) begin
                        n_res.status = abst_pkg::ST_DUPLICATE;
                    end else begin
                        n_res.status  = abst_pkg::ST_FOUND;
                        n_res.index   = abst_pkg::t_index'(r_cur);
                        n_res.payload = i_rd_pay;
                    end
                    n_state = S_RESULT;
                end else if (link < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = link[AW-1:0];
                    n_cur     = link[AW-1:0];
                end else if (r_op == abst_pkg::OP_INSERT) begin
                    n_last     = r_cur;
                    n_dir_left = key_less;
                    n_state    = S_WRITE_PARENT;
                end else begin
                    n_res.status = abst_pkg::ST_NOT_FOUND;
                    n_state      = S_RESULT;
                end
            end
            S_WRITE_PARENT: begin
                o_we.left  = r_dir_left;
                o_we.right = !r_dir_left;
                o_wr_addr  = r_last;
                n_state    = S_WRITE_NEW;
            end
            S_WRITE_NEW: begin
                o_we       = '{node: 1'b1, left: 1'b1, right: 1'b1};
                o_wr_addr  = r_count[AW-1:0];
                o_wr_left  = NO_CHILD;
                o_wr_right = NO_CHILD;
                n_count    = r_count + LW'(1);
                n_res.status = abst_pkg::ST_INSERTED;
                n_res.index  = abst_pkg::t_index'(r_count[AW-1:0]);
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_key      <= n_key;
            r_pay      <= n_pay;
            r_cur      <= n_cur;
            r_last     <= n_last;
            r_dir_left <= n_dir_left;
            r_count    <= n_count;
            r_res      <= n_res;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_res_valid = r_state == S_RESULT;
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("entry count beyond capacity");

    a_count_grows_on_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WRITE_NEW) |=> $stable(r_count))
        else $error("entry count changed outside node allocation");

    a_no_read_during_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we.node || o_we.left || o_we.right) |-> !o_rd_en)
        else $error("memory read overlaps a write");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> (LW'(r_cur) < r_count))
        else $error("walk visits an unallocated node");

    a_find_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_op == abst_pkg::OP_FIND) |->
        (r_res.status == abst_pkg::ST_FOUND || r_res.status == abst_pkg::ST_NOT_FOUND))
        else $error("find reports an insert status");

endmodule

FILE: hw/rtl/array_bst_insert_find.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      i_in_valid/o_in_stall   i_op, i_key, i_payload
// out      output     o_out_valid/i_out_stall o_status, o_index, o_found_payload
//
// One item at a time. A find, or an insert of a key already present, walks the
// tree from the root and ends at the key or at a missing child; the walk reads
// one node per cycle from the node memory. An insert of a new key then writes the
// parent's link and after that the new node. A full table or a find in an empty
// tree answers without a read; the first insert writes only the new node.
// Reset clears the entry count, state and output valid, not the node memory; no clearing pass is needed.
// The result register lets the next item be taken while a result is stalled.
module array_bst_insert_find #(
    parameter int CAPACITY = abst_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic [abst_pkg::KEY_W-1:0]         i_key,
    input  logic [abst_pkg::PAY_W-1:0]         i_payload,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_status,
    output logic [abst_pkg::INDEX_W-1:0]       o_index,
    output logic [abst_pkg::PAY_W-1:0]         o_found_payload
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = AW + 1;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [abst_pkg::KEY_W-1:0] rd_key;
    logic [abst_pkg::PAY_W-1:0] rd_pay;
    logic [LW-1:0]              rd_left;
    logic [LW-1:0]              rd_right;
    abst_pkg::t_mem_we          we;
    logic [AW-1:0]              wr_addr;
    logic [abst_pkg::KEY_W-1:0] wr_key;
    logic [abst_pkg::PAY_W-1:0] wr_pay;
    logic [LW-1:0]              wr_left;
    logic [LW-1:0]              wr_right;
    logic                       res_valid;
    logic                       res_ready;
    abst_pkg::t_result          res;

    logic              r_out_valid, n_out_valid;
    abst_pkg::t_result r_out, n_out;

    abst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .LW    (LW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_pay   (rd_pay),
        .o_rd_left  (rd_left),
        .o_rd_right (rd_right),
        .i_we       (we),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_pay   (wr_pay),
        .i_wr_left  (wr_left),
        .i_wr_right (wr_right)
    );

    abst_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_payload   (i_payload),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_key    (rd_key),
        .i_rd_pay    (rd_pay),
        .i_rd_left   (rd_left),
        .i_rd_right  (rd_right),
        .o_we        (we),
        .o_wr_addr   (wr_addr),
        .o_wr_key    (wr_key),
        .o_wr_pay    (wr_pay),
        .o_wr_left   (wr_left),
        .o_wr_right  (wr_right),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The result register is free when empty or when its transfer completes now.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_index         = r_out.index;
    assign o_found_payload = r_out.payload;

endmodule
